[design/rsf_pkg.sv]
// Package for the range sample spike filter: field widths, register indexes,
// reset values, result source codes and the controller/datapath structs.
// Depends on nothing; every other file of the block but rsf_ram imports it.
`default_nettype none

package rsf_pkg;

  localparam int unsigned RAW_W   = 16;
  localparam int unsigned RANGE_W = 13;
  localparam int unsigned SRC_W   = 2;
  localparam int unsigned LIM_W   = 8;
  localparam int unsigned CFG_AW  = 2;
  localparam int unsigned CFG_DW  = 13;

  localparam int unsigned WINDOW_DEPTH_DEF = 8;

  localparam logic [RAW_W-1:0] RANGE_LIMIT = RAW_W'(6400);
  localparam logic [LIM_W-1:0] RUN_MAX     = LIM_W'(255);

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_INVALID_HOLD = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_SPIKE_HOLD   = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] REG_MAX_DEV      = CFG_AW'(2);

  localparam logic [LIM_W-1:0]   INVALID_HOLD_RST = LIM_W'(3);
  localparam logic [LIM_W-1:0]   SPIKE_HOLD_RST   = LIM_W'(3);
  localparam logic [RANGE_W-1:0] MAX_DEV_RST      = RANGE_W'(800);

  // Where a result's distance came from.
  localparam logic [SRC_W-1:0] SRC_AVG  = SRC_W'(0);
  localparam logic [SRC_W-1:0] SRC_HELD = SRC_W'(1);
  localparam logic [SRC_W-1:0] SRC_NONE = SRC_W'(2);

  typedef struct packed {
    logic load;        // capture the incoming item
    logic check;       // classify the reading, handle the invalid path
    logic walk_start;  // clear the window accumulators
    logic walk_step;   // one read/accumulate step over the window
    logic spike_eval;  // spike test and spike run update
    logic store;       // write the reading into the window
    logic avg_eval;    // empty-window check, divider start
    logic div_step;    // one quotient bit
    logic avg_load;    // take the quotient as the new held value
    logic emit;        // move the result into the output register
  } rsf_cmd_t;

  typedef struct packed {
    logic invalid;     // echo missing or range over the limit
    logic fill_ge2;    // two or more samples stored
    logic walk_done;   // window walk finished
    logic reject;      // spike rejected, held value returned
    logic cnt_zero;    // no nonzero sample in the window
    logic div_done;    // all quotient bits produced
    logic out_free;    // output register can take a result
  } rsf_status_t;

endpackage

`default_nettype wire

[design/rsf_in_if.sv]
// Input channel of the range sample spike filter: valid/ready and one reading.
// Depends on rsf_pkg for the field widths.
`default_nettype none

interface rsf_in_if;
  import rsf_pkg::*;

  logic               valid;
  logic               ready;
  logic               echo_seen;
  logic [RAW_W-1:0]   raw_range;

  modport source (output valid, output echo_seen, output raw_range, input ready);
  modport sink   (input valid, input echo_seen, input raw_range, output ready);
endinterface

`default_nettype wire

[design/rsf_out_if.sv]
// Output channel of the range sample spike filter: valid/ready and one result.
// Depends on rsf_pkg for the field widths.
`default_nettype none

interface rsf_out_if;
  import rsf_pkg::*;

  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_out;
  logic               range_valid;
  logic [SRC_W-1:0]   range_source;

  modport source (output valid, output range_out, output range_valid,
                  output range_source, input ready);
  modport sink   (input valid, input range_out, input range_valid,
                  input range_source, output ready);
endinterface

`default_nettype wire

[design/rsf_ram.sv]
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
`default_nettype none

module rsf_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[design/rsf_ctrl.sv]
// Controller of the range sample spike filter: sequences one item through
// check, window walks, spike test, store and division. Depends on rsf_pkg.
`default_nettype none

module rsf_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire rsf_pkg::rsf_status_t status_i,
  output      rsf_pkg::rsf_cmd_t    cmd_o
);
  import rsf_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_CHECK  = 9'b000000010,
    ST_WALK1  = 9'b000000100,
    ST_TEST   = 9'b000001000,
    ST_STORE  = 9'b000010000,
    ST_WALK2  = 9'b000100000,
    ST_AVG    = 9'b001000000,
    ST_DIVIDE = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (status_i.invalid) begin
          state_d = ST_EMIT;
        end else if (status_i.fill_ge2) begin
          cmd_o.walk_start = 1'b1;
          state_d          = ST_WALK1;
        end else begin
          state_d = ST_STORE;
        end
      end
      ST_WALK1: begin
        if (status_i.walk_done) begin
          state_d = ST_TEST;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      ST_TEST: begin
        cmd_o.spike_eval = 1'b1;
        state_d = status_i.reject ? ST_EMIT : ST_STORE;
      end
      ST_STORE: begin
        cmd_o.store      = 1'b1;
        cmd_o.walk_start = 1'b1;
        state_d          = ST_WALK2;
      end
      ST_WALK2: begin
        if (status_i.walk_done) begin
          state_d = ST_AVG;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      ST_AVG: begin
        cmd_o.avg_eval = 1'b1;
        state_d = status_i.cnt_zero ? ST_EMIT : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status_i.div_done) begin
          cmd_o.avg_load = 1'b1;
          state_d        = ST_EMIT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[design/rsf_dpath.sv]
// Datapath of the range sample spike filter: configuration registers, run
// counters, window RAM, accumulators, serial divider and output register.
// Depends on rsf_pkg and rsf_ram.
`default_nettype none

module rsf_dpath #(
  parameter int unsigned WINDOW_DEPTH = rsf_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rsf_pkg::CFG_AW-1:0]    cfg_idx_i,
  input  wire logic [rsf_pkg::CFG_DW-1:0]    cfg_data_i,
  input  wire logic                          echo_seen_i,
  input  wire logic [rsf_pkg::RAW_W-1:0]     raw_range_i,
  input  wire logic                          out_ready_i,
  output      logic                          out_valid_o,
  output      logic [rsf_pkg::RANGE_W-1:0]   range_out_o,
  output      logic                          range_valid_o,
  output      logic [rsf_pkg::SRC_W-1:0]     range_source_o,
  input  wire rsf_pkg::rsf_cmd_t             cmd_i,
  output      rsf_pkg::rsf_status_t          status_o
);
  import rsf_pkg::*;

  localparam int unsigned AW    = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W = RANGE_W + CNT_W;
  localparam int unsigned DC_W  = $clog2(SUM_W + 1);

  // Configuration.
  logic [LIM_W-1:0]   inv_limit_q, spk_limit_q;
  logic [RANGE_W-1:0] max_dev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_limit_q <= INVALID_HOLD_RST;
      spk_limit_q <= SPIKE_HOLD_RST;
      max_dev_q   <= MAX_DEV_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INVALID_HOLD: inv_limit_q <= cfg_data_i[LIM_W-1:0];
        REG_SPIKE_HOLD:   spk_limit_q <= cfg_data_i[LIM_W-1:0];
        REG_MAX_DEV:      max_dev_q   <= cfg_data_i[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic             echo_q;
  logic [RAW_W-1:0] raw_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      echo_q <= echo_seen_i;
      raw_q  <= raw_range_i;
    end
  end

  logic [RANGE_W-1:0] sample;
  assign sample = raw_q[RANGE_W-1:0];

  // Filter state.
  logic [RANGE_W-1:0] held_range_q;
  logic               held_valid_q;
  logic [LIM_W-1:0]   inv_run_q, spk_run_q;
  logic [AW-1:0]      wr_slot_q;
  logic [CNT_W-1:0]   fill_q;

  // Window walk.
  logic [CNT_W-1:0] rd_idx_q, cnt_q;
  logic             pend_q;
  logic [SUM_W-1:0] sum_q;
  logic [RANGE_W-1:0] rdata;

  rsf_ram #(
    .WIDTH (RANGE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (wr_slot_q),
    .wdata_i (sample),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Divider.
  logic [SUM_W-1:0] quot_q;
  logic [CNT_W-1:0] rem_q;
  logic [DC_W-1:0]  div_cnt_q;
  logic [CNT_W:0]   trial;
  logic             trial_ge;

  assign trial    = {rem_q, quot_q[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, cnt_q});

  // Result before the output register.
  logic [RANGE_W-1:0] res_range_q;
  logic               res_valid_q;
  logic [SRC_W-1:0]   res_src_q;

  // Classification and run updates.
  logic             invalid;
  logic [LIM_W-1:0] inv_next, spk_next;
  assign invalid  = !echo_q || (raw_q > RANGE_LIMIT);
  assign inv_next = (inv_run_q == RUN_MAX) ? inv_run_q : inv_run_q + LIM_W'(1);
  assign spk_next = (spk_run_q == RUN_MAX) ? spk_run_q : spk_run_q + LIM_W'(1);

  // Exact spike test on the window before the reading is stored.
  logic [SUM_W-1:0] scaled, limit, dev;
  logic             spike, reject;
  assign scaled = SUM_W'(sample) * SUM_W'(cnt_q);
  assign limit  = SUM_W'(max_dev_q) * SUM_W'(cnt_q);
  assign dev    = (scaled > sum_q) ? scaled - sum_q : sum_q - scaled;
  assign spike  = (cnt_q != '0) && (dev > limit);
  assign reject = spike && (spk_next <= spk_limit_q) && held_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_range_q <= '0;
      held_valid_q <= 1'b0;
      inv_run_q    <= '0;
      spk_run_q    <= '0;
      wr_slot_q    <= '0;
      fill_q       <= '0;
    end else begin
      if (cmd_i.check) begin
        if (invalid) begin
          inv_run_q <= inv_next;
          if (!(held_valid_q && inv_next <= inv_limit_q) && inv_next > inv_limit_q) begin
            held_range_q <= '0;
            held_valid_q <= 1'b0;
          end
        end else begin
          inv_run_q <= '0;
        end
      end
      if (cmd_i.spike_eval) begin
        spk_run_q <= reject ? spk_next : '0;
      end
      if (cmd_i.store) begin
        // A reading stored without a spike test also ends any spike run.
        spk_run_q <= '0;
        wr_slot_q <= (wr_slot_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wr_slot_q + AW'(1);
        if (fill_q < CNT_W'(WINDOW_DEPTH)) begin
          fill_q <= fill_q + CNT_W'(1);
        end
      end
      if (cmd_i.avg_eval && cnt_q == '0) begin
        held_range_q <= '0;
        held_valid_q <= 1'b0;
      end
      if (cmd_i.avg_load) begin
        held_range_q <= quot_q[RANGE_W-1:0];
        held_valid_q <= 1'b1;
      end
    end
  end

  // Walk, divider and result registers carry payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      rd_idx_q <= '0;
      pend_q   <= 1'b0;
      sum_q    <= '0;
      cnt_q    <= '0;
    end else if (cmd_i.walk_step) begin
      if (pend_q && rdata != '0) begin
        sum_q <= sum_q + SUM_W'(rdata);
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (rd_idx_q < fill_q) begin
        rd_idx_q <= rd_idx_q + CNT_W'(1);
        pend_q   <= 1'b1;
      end else begin
        pend_q <= 1'b0;
      end
    end

    if (cmd_i.avg_eval) begin
      quot_q    <= sum_q;
      rem_q     <= '0;
      div_cnt_q <= DC_W'(SUM_W);
    end else if (cmd_i.div_step) begin
      rem_q     <= trial_ge ? CNT_W'(trial - {1'b0, cnt_q}) : trial[CNT_W-1:0];
      quot_q    <= {quot_q[SUM_W-2:0], trial_ge};
      div_cnt_q <= div_cnt_q - DC_W'(1);
    end

    if (cmd_i.check && invalid) begin
      if (held_valid_q && inv_next <= inv_limit_q) begin
        res_range_q <= held_range_q;
        res_valid_q <= 1'b1;
        res_src_q   <= SRC_HELD;
      end else begin
        res_range_q <= '0;
        res_valid_q <= 1'b0;
        res_src_q   <= SRC_NONE;
      end
    end
    if (cmd_i.spike_eval && reject) begin
      res_range_q <= held_range_q;
      res_valid_q <= 1'b1;
      res_src_q   <= SRC_HELD;
    end
    if (cmd_i.avg_eval && cnt_q == '0) begin
      res_range_q <= '0;
      res_valid_q <= 1'b0;
      res_src_q   <= SRC_NONE;
    end
    if (cmd_i.avg_load) begin
      res_range_q <= quot_q[RANGE_W-1:0];
      res_valid_q <= 1'b1;
      res_src_q   <= SRC_AVG;
    end

    if (cmd_i.emit) begin
      range_out_o    <= res_range_q;
      range_valid_o  <= res_valid_q;
      range_source_o <= res_src_q;
    end
  end

  // Output register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_o           = '0;
    status_o.invalid   = invalid;
    status_o.fill_ge2  = (fill_q >= CNT_W'(2));
    status_o.walk_done = (rd_idx_q >= fill_q) && !pend_q;
    status_o.reject    = reject;
    status_o.cnt_zero  = (cnt_q == '0);
    status_o.div_done  = (div_cnt_q == '0);
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

[design/range_sample_spike_filter.sv]
// Top level of the range sample spike filter: joins controller, datapath and
// the two channel interfaces. Depends on rsf_pkg, rsf_in_if, rsf_out_if,
// rsf_ctrl and rsf_dpath.
//
// The block filters ultrasonic range readings one item at a time. Each input
// item carries an echo flag and a Q12.4 cm distance; each produces exactly one
// result item (Q9.4 cm distance, valid flag, source code). An invalid reading
// (no echo or above 6400) goes from the check straight to the output register
// without a window walk. For a valid reading, the window is walked through its
// single RAM read port once before the spike test and once after the store,
// and the average comes from a one-bit-per-cycle divider that produces SUM_W
// quotient bits, where SUM_W = 13 + clog2(WINDOW_DEPTH+1). A rejected spike
// skips the store, the second walk and the divider. While fewer than two
// samples are stored the first walk and the spike test are skipped. The
// window needs no clearing pass after reset: only slots below the fill count
// ever enter the sums. A finished result sits in an output register, so the
// next item is taken while the previous result waits; the block stalls only
// when a second result is ready and the output register is still full.
// Configuration writes (index 0 invalid hold limit, 1 spike hold limit,
// 2 maximum deviation) take effect at once and belong in idle periods.
`default_nettype none

module range_sample_spike_filter #(
  parameter int unsigned WINDOW_DEPTH = rsf_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [rsf_pkg::CFG_AW-1:0] cfg_idx_i,
  input  wire logic [rsf_pkg::CFG_DW-1:0] cfg_data_i,
  rsf_in_if.sink                          in_i,
  rsf_out_if.source                       out_o
);
  import rsf_pkg::*;

  rsf_cmd_t    cmd;
  rsf_status_t status;

  rsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rsf_dpath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .echo_seen_i    (in_i.echo_seen),
    .raw_range_i    (in_i.raw_range),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .range_out_o    (out_o.range_out),
    .range_valid_o  (out_o.range_valid),
    .range_source_o (out_o.range_source),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule

`default_nettype wire
